FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IEBM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IEBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/iebm_pkg.sv
// Shared types, codes and tables of the I2C EEPROM byte master.
// No dependencies; imported by iebm_seq, iebm_out_buf and the top level.
package iebm_pkg;

  // Request codes carried by req_type
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHalfPhase     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWriteRecovery = 2'd1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  HalfPhaseRst     = 8'd10;
  localparam logic [15:0] WriteRecoveryRst = 16'd10000;

  // Transaction status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBusBusy  = 2'd1;
  localparam logic [1:0] StBusError = 2'd2;
  localparam logic [1:0] StAddrNack = 2'd3;

  // Program layout
  localparam logic [3:0] ProgLen      = 4'd11;
  localparam logic [3:0] LastIdx      = 4'd10;
  localparam logic [3:0] StopIdxWrite = 4'd7;
  localparam logic [3:0] StopIdxRead  = 4'd10;

  typedef enum logic [3:0] {
    KStart    = 4'd0,
    KRestart  = 4'd1,
    KSendDw   = 4'd2,
    KSendReg  = 4'd3,
    KSendData = 4'd4,
    KSendDr   = 4'd5,
    KAckCheck = 4'd6,
    KAck      = 4'd7,
    KRead     = 4'd8,
    KNoAck    = 4'd9,
    KStop     = 4'd10,
    KRecover  = 4'd11
  } iebm_op_e;

  // One result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } iebm_res_t;

  // Operation program of a byte write and of a random read
  function automatic iebm_op_e prog_kind(logic is_rd, logic [3:0] idx);
    iebm_op_e k;
    if (!is_rd) begin
      unique case (idx)
        4'd0:    k = KStart;
        4'd1:    k = KSendDw;
        4'd2:    k = KAckCheck;
        4'd3:    k = KSendReg;
        4'd4:    k = KAck;
        4'd5:    k = KSendData;
        4'd6:    k = KAck;
        4'd7:    k = KStop;
        default: k = KRecover;
      endcase
    end else begin
      unique case (idx)
        4'd0:    k = KStart;
        4'd1:    k = KSendDw;
        4'd2:    k = KAckCheck;
        4'd3:    k = KSendReg;
        4'd4:    k = KAck;
        4'd5:    k = KRestart;
        4'd6:    k = KSendDr;
        4'd7:    k = KAck;
        4'd8:    k = KRead;
        4'd9:    k = KNoAck;
        default: k = KStop;
      endcase
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/iebm_seq.sv
// Bus sequencer of the I2C EEPROM byte master: state register plus the
// one-tick next-state logic. Depends on iebm_pkg.
module iebm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          req_type_i,
  input  logic [6:0]          device_address_i,
  input  logic [7:0]          register_address_i,
  input  logic [7:0]          write_data_i,
  input  logic                sda_in_i,
  input  logic [7:0]          half_phase_i,
  input  logic [15:0]         recovery_i,
  output iebm_pkg::iebm_res_t res_o
);
  import iebm_pkg::*;

  typedef struct packed {
    logic [5:0]  step;
    logic [7:0]  timer;
    logic [3:0]  bitcnt;
    logic [7:0]  shift;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [7:0]  data;
    logic        is_read;
    logic [15:0] rec;
    logic [1:0]  last_status;
    logic [7:0]  last_read;
    logic [1:0]  drive;
    logic [1:0]  pending;
  } seq_state_t;

  localparam seq_state_t StateRst = '{
    step: 6'd0, timer: 8'd0, bitcnt: 4'd0, shift: 8'd0, dev: 7'd0,
    regad: 8'd0, data: 8'd0, is_read: 1'b0, rec: 16'd0,
    last_status: 2'd0, last_read: 8'd0, drive: 2'b11, pending: 2'd0
  };

  function automatic logic [3:0] op_index(seq_state_t s);
    logic [3:0] op;
    op = s.step[5:2] - 4'd1;
    return (op < ProgLen) ? op : LastIdx;
  endfunction

  function automatic seq_state_t enter_phase(seq_state_t s_in);
    seq_state_t s;
    logic [1:0] sub;
    logic       keep;
    s    = s_in;
    sub  = s.step[1:0];
    keep = s.drive[0];
    unique case (prog_kind(s.is_read, op_index(s)))
      KStart, KRestart: s.drive = (sub == 2'd0) ? 2'b11 : 2'b10;
      KSendDw, KSendReg, KSendData, KSendDr: begin
        if (sub == 2'd0)      s.drive = {1'b0, keep};
        else if (sub == 2'd1) s.drive = {1'b0, s.shift[7]};
        else                  s.drive = {1'b1, keep};
      end
      KAckCheck, KAck, KNoAck: begin
        if (sub == 2'd0)      s.drive = {1'b0, keep};
        else if (sub == 2'd2) s.drive = 2'b11;
        else                  s.drive = 2'b01;
      end
      KRead: s.drive = {sub != 2'd0, 1'b1};
      KStop: begin
        unique case (sub)
          2'd0:    s.drive = {1'b0, keep};
          2'd1:    s.drive = 2'b00;
          2'd2:    s.drive = 2'b10;
          default: s.drive = 2'b11;
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic seq_state_t begin_op(seq_state_t s_in, logic [3:0] idx_in);
    seq_state_t s;
    logic [3:0] idx;
    iebm_op_e   kind;
    s        = s_in;
    idx      = (idx_in >= ProgLen) ? LastIdx : idx_in;
    s.step   = {idx + 4'd1, 2'b00};
    s.bitcnt = 4'd0;
    kind     = prog_kind(s.is_read, idx);
    if (kind == KSendDw)        s.shift = {s.dev, 1'b0};
    else if (kind == KSendDr)   s.shift = {s.dev, 1'b1};
    else if (kind == KSendReg)  s.shift = s.regad;
    else if (kind == KSendData) s.shift = s.data;
    else if (kind == KRead)     s.shift = 8'd0;
    return enter_phase(s);
  endfunction

  function automatic seq_state_t finish(seq_state_t s_in, logic [1:0] st);
    seq_state_t s;
    s = s_in;
    s.last_status = st;
    if (s.is_read) s.last_read = (st == StOk) ? s.shift : 8'd0;
    s.step  = 6'd0;
    s.timer = 8'd0;
    return s;
  endfunction

  function automatic seq_state_t end_phase(seq_state_t s_in, logic sda,
                                           logic [15:0] rec_ticks);
    seq_state_t s;
    logic [1:0] sub;
    logic [3:0] idx;
    iebm_op_e   kind;
    s    = s_in;
    sub  = s.step[1:0];
    idx  = op_index(s);
    kind = prog_kind(s.is_read, idx);
    unique case (kind)
      KStart: begin
        if (sub == 2'd0 && !sda)     s = finish(s, StBusBusy);
        else if (sub == 2'd1 && sda) s = finish(s, StBusError);
        else if (sub < 2'd2) begin
          s.step = s.step + 6'd1;
          s = enter_phase(s);
        end else s = begin_op(s, idx + 4'd1);
      end
      KRestart: begin
        if (sub < 2'd2) begin
          s.step = s.step + 6'd1;
          s = enter_phase(s);
        end else s = begin_op(s, idx + 4'd1);
      end
      KSendDw, KSendReg, KSendData, KSendDr: begin
        if (sub < 2'd2) begin
          s.step = s.step + 6'd1;
          s = enter_phase(s);
        end else begin
          s.shift  = {s.shift[6:0], 1'b0};
          s.bitcnt = s.bitcnt + 4'd1;
          if (s.bitcnt >= 4'd8) s = begin_op(s, idx + 4'd1);
          else begin
            s.step[1:0] = 2'd0;
            s = enter_phase(s);
          end
        end
      end
      KAckCheck, KAck, KNoAck: begin
        if (kind == KAckCheck && sub == 2'd2 && sda) s.pending = StAddrNack;
        if (sub < 2'd3) begin
          s.step = s.step + 6'd1;
          s = enter_phase(s);
        end else if (s.pending != StOk) begin
          s = begin_op(s, s.is_read ? StopIdxRead : StopIdxWrite);
        end else s = begin_op(s, idx + 4'd1);
      end
      KRead: begin
        if (sub == 2'd0) begin
          s.step = s.step + 6'd1;
          s = enter_phase(s);
        end else begin
          s.shift  = {s.shift[6:0], sda};
          s.bitcnt = s.bitcnt + 4'd1;
          if (s.bitcnt >= 4'd8) s = begin_op(s, idx + 4'd1);
          else begin
            s.step[1:0] = 2'd0;
            s = enter_phase(s);
          end
        end
      end
      KStop: begin
        if (sub < 2'd3) begin
          s.step = s.step + 6'd1;
          s = enter_phase(s);
        end else if (s.is_read || s.pending != StOk || rec_ticks == 16'd0) begin
          s = finish(s, s.pending);
        end else begin
          s.rec = rec_ticks;
          s = begin_op(s, idx + 4'd1);
        end
      end
      default: s = finish(s, s.pending);
    endcase
    return s;
  endfunction

  seq_state_t state_q, state_d;
  logic [1:0] now_drive;
  logic       active;
  logic [7:0] half_eff;

  always_comb begin
    state_d = state_q;
    // Latch a new command only between transactions
    if (state_q.step == 6'd0 && (req_type_i == ReqWrite || req_type_i == ReqRead)) begin
      state_d.dev     = device_address_i;
      state_d.regad   = register_address_i;
      state_d.data    = write_data_i;
      state_d.is_read = (req_type_i == ReqRead);
      state_d.pending = StOk;
      state_d.timer   = 8'd0;
      state_d = begin_op(state_d, 4'd0);
    end
    now_drive = state_d.drive;
    active    = (state_d.step != 6'd0);
    half_eff  = (half_phase_i == 8'd0) ? 8'd1 : half_phase_i;
    if (active) begin
      if (prog_kind(state_d.is_read, op_index(state_d)) == KRecover) begin
        if (state_d.rec != 16'd0) state_d.rec = state_d.rec - 16'd1;
        if (state_d.rec == 16'd0) state_d = finish(state_d, StOk);
      end else begin
        state_d.timer = state_d.timer + 8'd1;
        if (state_d.timer >= half_eff) begin
          state_d.timer = 8'd0;
          state_d = end_phase(state_d, sda_in_i, recovery_i);
        end
      end
    end
    res_o.scl_out   = now_drive[1];
    res_o.sda_out   = now_drive[0];
    res_o.busy_res  = (state_d.step != 6'd0);
    res_o.done_res  = active && (state_d.step == 6'd0);
    res_o.status    = state_d.last_status;
    res_o.read_data = state_d.last_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/iebm_out_buf.sv
// Two-entry output buffer (result register plus skid) of the byte master.
// Depends on iebm_pkg.
module iebm_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  iebm_pkg::iebm_res_t res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output iebm_pkg::iebm_res_t res_o,
  output logic                full_o
);
  import iebm_pkg::*;

  logic      main_valid_q, skid_valid_q;
  iebm_res_t main_q, skid_q;
  logic      pop;

  assign pop = main_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) skid_valid_q <= 1'b1;
      else              main_valid_q <= 1'b1;
    end
  end

  // Payload: refill main from skid or input, park in skid while main holds
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end else if (push_i && (pop || !main_valid_q)) begin
      main_q <= res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign res_o       = main_q;
  assign full_o      = skid_valid_q;

endmodule

FILE: hw/rtl/i2c_eeprom_byte_master.sv
// Top level of the I2C EEPROM byte master: configuration registers,
// sequencer and output buffer. Depends on iebm_pkg, iebm_seq, iebm_out_buf.
//
// Each input transfer is one bus tick and yields exactly one result transfer,
// so the block takes one item per clock cycle while in_stall_o is low. The
// sequencer state register is loaded by combinational next-state logic; results
// pass through a two-entry output buffer, and in_stall_o rises only when both
// entries hold unread results. A byte write or random read command is latched
// only while no transaction runs; scl_out/sda_out are open-drain drives (1
// releases, 0 pulls low). Configuration writes take effect on the next tick.
module i2c_eeprom_byte_master (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [iebm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [iebm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic [6:0]                      device_address_i,
  input  logic [7:0]                      register_address_i,
  input  logic [7:0]                      write_data_i,
  input  logic                            sda_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            scl_out_o,
  output logic                            sda_out_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [1:0]                      status_o,
  output logic [7:0]                      read_data_o
);
  import iebm_pkg::*;

  logic [7:0]  half_phase_q;
  logic [15:0] recovery_q;
  logic        in_xfer;
  iebm_res_t   seq_res, buf_res;

  // Hold configuration; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_phase_q <= HalfPhaseRst;
      recovery_q   <= WriteRecoveryRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPhase:     half_phase_q <= cfg_wdata_i[7:0];
        CfgWriteRecovery: recovery_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the sequencer on every accepted input transfer
  assign in_xfer = in_valid_i && !in_stall_o;

  iebm_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (in_xfer),
    .req_type_i         (req_type_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .write_data_i       (write_data_i),
    .sda_in_i           (sda_in_i),
    .half_phase_i       (half_phase_q),
    .recovery_i         (recovery_q),
    .res_o              (seq_res)
  );

  iebm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .res_i       (seq_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (buf_res),
    .full_o      (in_stall_o)
  );

  assign scl_out_o   = buf_res.scl_out;
  assign sda_out_o   = buf_res.sda_out;
  assign busy_res_o  = buf_res.busy_res;
  assign done_res_o  = buf_res.done_res;
  assign status_o    = buf_res.status;
  assign read_data_o = buf_res.read_data;

endmodule

FILE: hw/rtl/iebm_checker.sv
// Port-level checker of the I2C EEPROM byte master and its bind.
// Depends on assert_macros.svh and the top level's port names.
`include "assert_macros.svh"

module iebm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       scl_out_o,
  input logic       sda_out_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [1:0] status_o,
  input logic [7:0] read_data_o
);

  // A finishing tick never reports the transaction as still running
  `IEBM_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o, "done with busy set")

  // The skid entry is only occupied behind a held result
  `IEBM_ASSERT_NOW(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with no result waiting")

  // Input backpressure appears only after the output side stalled
  `IEBM_ASSERT_NEXT(a_stall_cause, clk_i, rst_ni, !in_stall_o && !(out_valid_o && out_stall_i), !in_stall_o, "input stalled without output stall")

  // A stalled result holds
  `IEBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(read_data_o) && $stable(done_res_o) && $stable(busy_res_o) && $stable(scl_out_o) && $stable(sda_out_o), "stalled result changed")

endmodule

bind i2c_eeprom_byte_master iebm_checker u_iebm_checker (.*);
